/* rtl/vote_lockout_stack_assert.svh */
// Assertion macros used by the vote stack checker.
`ifndef VOTE_LOCKOUT_STACK_ASSERT_SVH
`define VOTE_LOCKOUT_STACK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VLS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vls_pkg.sv */
// Types, constants and sequencer states of the vote lockout stack.
package vls_pkg;

    localparam int SLOT_W            = 64;
    localparam int CNT_W             = 6;
    localparam int PTR_W             = 5;
    localparam int STACK_CAP         = 31;
    localparam int HISTORY_DEPTH_DEF = 31;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(63);
    localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

    localparam logic MODE_VOTE    = 1'b0;
    localparam logic MODE_CONFIRM = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
    } t_vls_in;

    typedef struct packed {
        logic [SLOT_W-1:0] root_pos;
        logic              root_changed;
        logic [PTR_W-1:0]  stack_depth;
        logic [SLOT_W-1:0] last_vote;
        logic [SLOT_W-1:0] vote_credits;
        logic              slot_found;
    } t_vls_out;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } t_vls_entry;

    typedef struct packed {
        logic             gt;
        logic             eq;
        logic [CNT_W-1:0] bump;
        logic             at_lim;
    } t_vls_alu_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_CMP,
        S_INC_RD,
        S_INC_WR,
        S_PUSH,
        S_CNF_RD,
        S_CNF_CMP,
        S_DONE
    } t_vls_state;

endpackage

/* rtl/vls_alu.sv */
// Shared compare and saturating count unit applied to one stack entry per step.
module vls_alu #(
    parameter int HISTORY_DEPTH = vls_pkg::HISTORY_DEPTH_DEF
) (
    input  vls_pkg::t_vls_entry         i_entry,
    input  logic [vls_pkg::SLOT_W-1:0]  i_slot,
    output vls_pkg::t_vls_alu_res       o_res
);

    logic [vls_pkg::CNT_W-1:0] bump;

    assign bump = (i_entry.count == vls_pkg::COUNT_MAX) ? i_entry.count
                                                         : i_entry.count + vls_pkg::COUNT_ONE;

    assign o_res.gt     = i_entry.slot > i_slot;
    assign o_res.eq     = i_entry.slot == i_slot;
    assign o_res.bump   = bump;
    assign o_res.at_lim = bump >= vls_pkg::CNT_W'(HISTORY_DEPTH);

endmodule

/* rtl/vls_engine.sv */
// Sequencer, stack memory and state registers of the vote lockout stack.
module vls_engine #(
    parameter int HISTORY_DEPTH = vls_pkg::HISTORY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vls_pkg::t_vls_in  i_in_data,
    output logic              o_done,
    input  logic              i_take,
    output vls_pkg::t_vls_out o_res
);

    localparam int MEM_DEPTH = 1 << vls_pkg::PTR_W;
    localparam logic [vls_pkg::PTR_W-1:0] PTR_ONE = vls_pkg::PTR_W'(1);

    vls_pkg::t_vls_state r_state, n_state;

    logic                         r_mode, n_mode;
    logic [vls_pkg::SLOT_W-1:0]   r_slot, n_slot;
    logic [vls_pkg::PTR_W-1:0]    r_base, n_base;
    logic [vls_pkg::PTR_W-1:0]    r_depth, n_depth;
    logic [vls_pkg::PTR_W-1:0]    r_ptr, n_ptr;
    logic [vls_pkg::PTR_W-1:0]    r_left, n_left;
    logic [vls_pkg::SLOT_W-1:0]   r_root, n_root;
    logic [vls_pkg::SLOT_W-1:0]   r_last, n_last;
    logic [vls_pkg::SLOT_W-1:0]   r_credit, n_credit;
    logic                         r_changed, n_changed;
    logic                         r_found, n_found;
    vls_pkg::t_vls_entry          r_rd;

    vls_pkg::t_vls_entry          mem [MEM_DEPTH];

    vls_pkg::t_vls_alu_res        alu;
    logic                         push_ok;
    logic                         promote;
    logic                         mem_we;
    logic [vls_pkg::PTR_W-1:0]    mem_waddr;
    logic [vls_pkg::PTR_W-1:0]    mem_raddr;
    vls_pkg::t_vls_entry          mem_wdata;

    vls_alu #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_alu (
        .i_entry(r_rd),
        .i_slot (r_slot),
        .o_res  (alu)
    );

    assign push_ok = (vls_pkg::CNT_W'(r_depth) < vls_pkg::CNT_W'(HISTORY_DEPTH))
                  && (r_depth != vls_pkg::PTR_W'(vls_pkg::STACK_CAP));
    assign promote = (r_ptr == r_base) && alu.at_lim;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vls_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.mode == vls_pkg::MODE_CONFIRM) ? vls_pkg::S_CNF_RD
                                                                        : vls_pkg::S_POP_RD;
                end
            end
            vls_pkg::S_POP_RD:  n_state = (r_depth == '0) ? vls_pkg::S_PUSH : vls_pkg::S_POP_CMP;
            vls_pkg::S_POP_CMP: n_state = alu.gt ? vls_pkg::S_POP_RD : vls_pkg::S_INC_RD;
            vls_pkg::S_INC_RD:  n_state = vls_pkg::S_INC_WR;
            vls_pkg::S_INC_WR:  n_state = (r_left == PTR_ONE) ? vls_pkg::S_PUSH : vls_pkg::S_INC_RD;
            vls_pkg::S_PUSH:    n_state = vls_pkg::S_DONE;
            vls_pkg::S_CNF_RD:  n_state = (r_left == '0) ? vls_pkg::S_DONE : vls_pkg::S_CNF_CMP;
            vls_pkg::S_CNF_CMP: n_state = alu.eq ? vls_pkg::S_DONE : vls_pkg::S_CNF_RD;
            vls_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = vls_pkg::S_IDLE;
                end
            end
            default:   n_state = vls_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != vls_pkg::S_IDLE);
        o_done     = (r_state == vls_pkg::S_DONE);
        mem_raddr  = r_ptr;
        mem_we     = 1'b0;
        mem_waddr  = r_ptr;
        mem_wdata  = '{slot: r_rd.slot, count: alu.bump};
        unique case (r_state)
            vls_pkg::S_POP_RD: begin
                mem_raddr = r_base + r_depth - PTR_ONE;
            end
            vls_pkg::S_INC_WR: begin
                mem_we = !promote;
            end
            vls_pkg::S_PUSH: begin
                mem_we    = push_ok;
                mem_waddr = r_base + r_depth;
                mem_wdata = '{slot: r_slot, count: vls_pkg::COUNT_ONE};
            end
            vls_pkg::S_CNF_CMP: begin
                mem_we = alu.eq && !alu.at_lim;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_slot    = r_slot;
        n_base    = r_base;
        n_depth   = r_depth;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_root    = r_root;
        n_last    = r_last;
        n_credit  = r_credit;
        n_changed = r_changed;
        n_found   = r_found;
        case (r_state)
            vls_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mode    = i_in_data.mode;
                    n_slot    = i_in_data.slot;
                    n_changed = 1'b0;
                    n_found   = 1'b0;
                    n_ptr     = r_base;
                    n_left    = r_depth;
                end
            end
            vls_pkg::S_POP_CMP: begin
                if (alu.gt) begin
                    n_depth = r_depth - PTR_ONE;
                end else begin
                    n_ptr  = r_base;
                    n_left = r_depth;
                end
            end
            vls_pkg::S_INC_WR: begin
                n_ptr  = r_ptr + PTR_ONE;
                n_left = r_left - PTR_ONE;
                if (promote) begin
                    n_root    = r_rd.slot;
                    n_changed = 1'b1;
                    n_base    = r_base + PTR_ONE;
                    n_depth   = r_depth - PTR_ONE;
                end
            end
            vls_pkg::S_PUSH: begin
                if (push_ok) begin
                    n_depth = r_depth + PTR_ONE;
                end
                n_last   = r_slot;
                n_credit = r_credit + vls_pkg::SLOT_W'(1);
            end
            vls_pkg::S_CNF_CMP: begin
                if (alu.eq) begin
                    n_found = 1'b1;
                    if (alu.at_lim) begin
                        n_root    = r_slot;
                        n_changed = 1'b1;
                        n_base    = r_ptr + PTR_ONE;
                        n_depth   = r_left - PTR_ONE;
                    end
                end else begin
                    n_ptr  = r_ptr + PTR_ONE;
                    n_left = r_left - PTR_ONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vls_pkg::S_IDLE;
            r_base   <= '0;
            r_depth  <= '0;
            r_root   <= '0;
            r_last   <= '0;
            r_credit <= '0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_depth  <= n_depth;
            r_root   <= n_root;
            r_last   <= n_last;
            r_credit <= n_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_slot    <= n_slot;
        r_ptr     <= n_ptr;
        r_left    <= n_left;
        r_changed <= n_changed;
        r_found   <= n_found;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    assign o_res.root_pos     = r_root;
    assign o_res.root_changed = r_changed;
    assign o_res.stack_depth  = r_depth;
    assign o_res.last_vote    = r_last;
    assign o_res.vote_credits = r_credit;
    assign o_res.slot_found   = r_found && (r_mode == vls_pkg::MODE_CONFIRM);

endmodule

/* rtl/vote_lockout_stack.sv */
// Top level of the vote lockout stack: sequencer plus result register.
// One transaction in, one result out. The stack lives in a 32-entry
// single-write memory with a registered read port, addressed as a ring
// from a base pointer, and one shared compare/increment unit visits one
// entry per step. A vote first pops the entries whose slot is greater
// than its own, each with a read and a compare state, then reads and
// writes back each remaining entry with its count bumped, skipping this
// when popping empties the stack, and ends with a push; a confirm reads
// and compares entries from the bottom until it finds a match or runs
// out. The sequencer returns to idle before the next transaction is taken.
// The block stalls its input while an item is in progress and takes the
// next transaction as soon as the previous result sits in the output
// register, even if that result is still stalled downstream.
module vote_lockout_stack #(
    parameter int HISTORY_DEPTH = vls_pkg::HISTORY_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vls_pkg::t_vls_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output vls_pkg::t_vls_out o_out_data
);

    logic              done;
    logic              take;
    vls_pkg::t_vls_out res;
    logic              r_out_valid, n_out_valid;
    vls_pkg::t_vls_out r_out_data;

    vls_engine #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data (i_in_data),
        .o_done    (done),
        .i_take    (take),
        .o_res     (res)
    );

    assign take        = !r_out_valid || !i_out_stall;
    assign n_out_valid = (done && take) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/vls_checker.sv */
// Port-level checker for the vote lockout stack and its bind.
`include "vote_lockout_stack_assert.svh"

module vls_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_stall,
    input logic              i_out_valid,
    input logic              i_out_stall,
    input vls_pkg::t_vls_out i_out_data
);

    logic in_xfer;
    logic found_and_promoted;

    assign in_xfer            = i_in_valid && !i_in_stall;
    assign found_and_promoted = i_out_valid && i_out_data.slot_found
                             && i_out_data.root_changed;

    `VLS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_xfer, i_in_stall, "input not stalled after accept")
    `VLS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data), "stalled result changed")
    `VLS_ASSERT_IMPLIES(a_result_from_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_stall), "result without work in progress")
    `VLS_ASSERT_IMPLIES(a_confirm_shrinks, i_clk, i_rst_n, found_and_promoted, i_out_data.stack_depth != vls_pkg::PTR_W'(vls_pkg::STACK_CAP), "root advance left a full stack")

endmodule

bind vote_lockout_stack vls_checker u_vls_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_data (o_out_data)
);

/* tb/vote_lockout_stack_test.sv */
// Self-checking testbench for the vote lockout stack: directed table, then random vote and confirm runs.
module vote_lockout_stack_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOCK_DEPTH = vls_pkg::HISTORY_DEPTH_DEF;
    localparam int RAND_ITEMS = 1234;
    localparam logic [vls_pkg::SLOT_W-1:0] SLOT_TOP = '1;

    typedef struct {
        vls_pkg::t_vls_in  item;
        bit                typed;
        vls_pkg::t_vls_out want;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    vls_pkg::t_vls_in  i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    vls_pkg::t_vls_out o_out_data;

    logic [vls_pkg::SLOT_W-1:0] tower_slot [vls_pkg::STACK_CAP];
    logic [vls_pkg::CNT_W-1:0]  tower_cnt [vls_pkg::STACK_CAP];
    int                         tower_n;
    logic [vls_pkg::SLOT_W-1:0] root_now;
    logic [vls_pkg::SLOT_W-1:0] last_now;
    logic [vls_pkg::SLOT_W-1:0] credits_now;

    vls_pkg::t_vls_out results_due [$];
    int unsigned       fault_count = 0;
    bit                calm_tail = 1'b0;
    bit                steady = 1'b0;
    logic              hold_go;

    vote_lockout_stack #(
        .HISTORY_DEPTH(LOCK_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [vls_pkg::CNT_W-1:0] bumped(input logic [vls_pkg::CNT_W-1:0] c);
        return (c == vls_pkg::COUNT_MAX) ? vls_pkg::COUNT_MAX : c + vls_pkg::COUNT_ONE;
    endfunction

    function automatic void shed_bottom(input int n);
        if (n >= tower_n) begin
            tower_n = 0;
            return;
        end
        for (int k = 0; k < tower_n - n; k++) begin
            tower_slot[k] = tower_slot[k + n];
            tower_cnt[k]  = tower_cnt[k + n];
        end
        tower_n = tower_n - n;
    endfunction

    function automatic vls_pkg::t_vls_out advance_vote_stack(input vls_pkg::t_vls_in it);
        vls_pkg::t_vls_out r;
        bit                promoted;
        bit                hit;
        promoted = 1'b0;
        hit = 1'b0;
        if (it.mode == vls_pkg::MODE_VOTE) begin
            while (tower_n > 0 && tower_slot[tower_n - 1] > it.slot)
                tower_n--;
            for (int i = 0; i < tower_n; i++)
                tower_cnt[i] = bumped(tower_cnt[i]);
            while (tower_n > 0 && tower_cnt[0] >= LOCK_DEPTH) begin
                root_now = tower_slot[0];
                promoted = 1'b1;
                shed_bottom(1);
            end
            if (tower_n < LOCK_DEPTH && tower_n < vls_pkg::STACK_CAP) begin
                tower_slot[tower_n] = it.slot;
                tower_cnt[tower_n]  = vls_pkg::COUNT_ONE;
                tower_n++;
            end
            last_now = it.slot;
            credits_now = credits_now + 1'b1;
        end else begin
            for (int i = 0; i < tower_n; i++) begin
                if (tower_slot[i] == it.slot) begin
                    hit = 1'b1;
                    tower_cnt[i] = bumped(tower_cnt[i]);
                    if (tower_cnt[i] >= LOCK_DEPTH) begin
                        root_now = it.slot;
                        promoted = 1'b1;
                        shed_bottom(i + 1);
                    end
                    break;
                end
            end
        end
        r.root_pos     = root_now;
        r.root_changed = promoted;
        r.stack_depth  = tower_n[vls_pkg::PTR_W-1:0];
        r.last_vote    = last_now;
        r.vote_credits = credits_now;
        r.slot_found   = hit;
        return r;
    endfunction

    function automatic t_dir_row make_row(
        input logic mode, input logic [vls_pkg::SLOT_W-1:0] slot, input bit typed = 1'b0,
        input logic [vls_pkg::SLOT_W-1:0] root = '0, input logic chg = 1'b0,
        input logic [vls_pkg::PTR_W-1:0] depth = '0,
        input logic [vls_pkg::SLOT_W-1:0] last = '0,
        input logic [vls_pkg::SLOT_W-1:0] cred = '0, input logic found = 1'b0);
        t_dir_row d;
        d.item.mode         = mode;
        d.item.slot         = slot;
        d.typed             = typed;
        d.want.root_pos     = root;
        d.want.root_changed = chg;
        d.want.stack_depth  = depth;
        d.want.last_vote    = last;
        d.want.vote_credits = cred;
        d.want.slot_found   = found;
        return d;
    endfunction

    task automatic offer(input vls_pkg::t_vls_in it, input vls_pkg::t_vls_out want);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        results_due.push_back(want);
        if (!calm_tail && !steady && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic check_result(input vls_pkg::t_vls_out got);
        vls_pkg::t_vls_out want;
        if (results_due.size() == 0) begin
            $error("unexpected transaction: root_pos %h depth %0d", got.root_pos,
                   got.stack_depth);
            fault_count++;
            return;
        end
        want = results_due.pop_front();
        if (got.root_pos !== want.root_pos) begin
            $error("root_pos: expected %h, got %h", want.root_pos, got.root_pos);
            fault_count++;
        end
        if (got.root_changed !== want.root_changed) begin
            $error("root_changed: expected %b, got %b", want.root_changed, got.root_changed);
            fault_count++;
        end
        if (got.stack_depth !== want.stack_depth) begin
            $error("stack_depth: expected %0d, got %0d", want.stack_depth, got.stack_depth);
            fault_count++;
        end
        if (got.last_vote !== want.last_vote) begin
            $error("last_vote: expected %h, got %h", want.last_vote, got.last_vote);
            fault_count++;
        end
        if (got.vote_credits !== want.vote_credits) begin
            $error("vote_credits: expected %h, got %h", want.vote_credits, got.vote_credits);
            fault_count++;
        end
        if (got.slot_found !== want.slot_found) begin
            $error("slot_found: expected %b, got %b", want.slot_found, got.slot_found);
            fault_count++;
        end
    endtask

    initial begin : drain
        int hold_left;
        int burst_left;
        bit hold_started;
        hold_left = 0;
        burst_left = 0;
        hold_started = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                check_result(o_out_data);
            if (hold_go && !hold_started) begin
                hold_started = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (!calm_tail && !steady && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 6) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        vls_pkg::t_vls_in           it;
        vls_pkg::t_vls_out          want;
        t_dir_row                   dir_rows [$];
        logic [vls_pkg::SLOT_W-1:0] seq_slot;
        int                         seq_left;
        int                         pick;
        int                         idx;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        hold_go    <= 1'b0;
        tower_n     = 0;
        root_now    = '0;
        last_now    = '0;
        credits_now = '0;
        seq_slot    = '0;
        seq_left    = 0;

        dir_rows.push_back(make_row(vls_pkg::MODE_CONFIRM, '0, 1'b1, '0, 1'b0, 5'd0, '0,
                                    64'd0, 1'b0));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, SLOT_TOP, 1'b1, '0, 1'b0, 5'd1,
                                    SLOT_TOP, 64'd1, 1'b0));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, '0, 1'b1, '0, 1'b0, 5'd1, '0,
                                    64'd2, 1'b0));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, '0, 1'b1, '0, 1'b0, 5'd2, '0,
                                    64'd3, 1'b0));
        dir_rows.push_back(make_row(vls_pkg::MODE_CONFIRM, '0, 1'b1, '0, 1'b0, 5'd2, '0,
                                    64'd3, 1'b1));
        dir_rows.push_back(make_row(vls_pkg::MODE_CONFIRM, SLOT_TOP, 1'b1, '0, 1'b0, 5'd2,
                                    '0, 64'd3, 1'b0));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, 64'h5555_5555_5555_5555));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, 64'hAAAA_AAAA_AAAA_AAAA));
        dir_rows.push_back(make_row(vls_pkg::MODE_CONFIRM, 64'h5555_5555_5555_5555));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, SLOT_TOP));
        dir_rows.push_back(make_row(vls_pkg::MODE_CONFIRM, '0));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, 64'h8000_0000_0000_0000));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, 64'd1));
        dir_rows.push_back(make_row(vls_pkg::MODE_CONFIRM, 64'd1));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, 64'h7FFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(make_row(vls_pkg::MODE_VOTE, 64'h7FFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(make_row(vls_pkg::MODE_CONFIRM, 64'h7FFF_FFFF_FFFF_FFFF));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            want = advance_vote_stack(dir_rows[r].item);
            if (dir_rows[r].typed)
                want = dir_rows[r].want;
            offer(dir_rows[r].item, want);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - 150)
                calm_tail = 1'b1;
            if (n == 300)
                hold_go <= 1'b1;
            if (n == 700) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (results_due.size() != 0);
            end
            if (seq_left == 0) begin
                seq_left = $urandom_range(20, 90);
                steady = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0: seq_slot = {$urandom, $urandom};
                    1: seq_slot = SLOT_TOP - $urandom_range(0, 200);
                    2: seq_slot = vls_pkg::SLOT_W'($urandom_range(0, 50));
                    default: seq_slot = {$urandom, $urandom} >> $urandom_range(0, 63);
                endcase
            end
            seq_left--;
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                seq_slot = seq_slot + $urandom_range(0, 3);
                it.mode = vls_pkg::MODE_VOTE;
                it.slot = seq_slot;
            end else if (pick < 84 && tower_n > 0) begin
                idx = $urandom_range(0, 1) ? tower_n - 1 : $urandom_range(0, tower_n - 1);
                it.mode = vls_pkg::MODE_CONFIRM;
                it.slot = tower_slot[idx];
            end else if (pick < 90) begin
                seq_slot = seq_slot - $urandom_range(1, 8);
                it.mode = vls_pkg::MODE_VOTE;
                it.slot = seq_slot;
            end else if (pick < 95) begin
                it.mode = vls_pkg::MODE_CONFIRM;
                it.slot = {$urandom, $urandom};
            end else begin
                it.mode = 1'($urandom_range(0, 1));
                it.slot = {$urandom, $urandom};
            end
            want = advance_vote_stack(it);
            offer(it, want);
        end

        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* vote_lockout_stack.f */
+incdir+rtl
rtl/vls_pkg.sv
rtl/vls_alu.sv
rtl/vls_engine.sv
rtl/vote_lockout_stack.sv
rtl/vls_checker.sv
tb/vote_lockout_stack_test.sv
